>>> hdl/mic_pkg.sv
// Shared types and constants for the MIPS integer subset core.
// Used by the controller, the datapath and the top level.
`default_nettype none
package mic_pkg;

    localparam logic [31:0] INSTR_BYTES  = 32'd4;
    localparam logic [31:0] EXIT_ADDRESS = 32'd4092;

    localparam logic [5:0] OP_SPECIAL = 6'b000000;
    localparam logic [5:0] OP_BEQ     = 6'b000100;
    localparam logic [5:0] OP_BNE     = 6'b000101;
    localparam logic [5:0] OP_LW      = 6'b100011;
    localparam logic [5:0] OP_SW      = 6'b101011;

    localparam logic [5:0] FN_ADD   = 6'b100000;
    localparam logic [5:0] FN_SUB   = 6'b100010;
    localparam logic [5:0] FN_MULT  = 6'b011000;
    localparam logic [5:0] FN_MULTU = 6'b011001;
    localparam logic [5:0] FN_DIV   = 6'b011010;
    localparam logic [5:0] FN_DIVU  = 6'b011011;
    localparam logic [5:0] FN_MFHI  = 6'b010000;
    localparam logic [5:0] FN_MFLO  = 6'b010010;
    localparam logic [5:0] FN_SLT   = 6'b101010;
    localparam logic [5:0] FN_SLTU  = 6'b101011;
    localparam logic [5:0] FN_LIS   = 6'b010100;
    localparam logic [5:0] FN_JR    = 6'b001000;
    localparam logic [5:0] FN_JALR  = 6'b001001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_MEM
    } state_t;

    typedef struct packed {
        logic load;
        logic halt;
        logic fetch;
        logic decode;
        logic exec;
        logic mul_fin;
        logic div_fin;
        logic mem_fin;
    } cmd_t;

    typedef struct packed {
        logic pc_ok;
        logic need_mul;
        logic need_div;
        logic need_mem;
        logic div_done;
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/mic_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned magnitudes only; sign fixup lives in the datapath.
`default_nettype none
module mic_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg, done_reg;
    logic [32:0] trial, diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= diff[32] ? trial[31:0] : diff[31:0];
            quo_reg <= {quo_reg[30:0], ~diff[32]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

>>> hdl/mic_ctrl.sv
// Controller state machine: sequences fetch, execute and the long operations.
// Depends on mic_pkg for the state type and the command/status structs.
`default_nettype none
module mic_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          opcode,
    input  mic_pkg::sts_t sts,
    output mic_pkg::cmd_t cmd,
    output logic          busy
);
    import mic_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!opcode)
                        cmd.load = 1'b1;
                    else if (!sts.pc_ok)
                        cmd.halt = 1'b1;
                    else
                    begin
                        cmd.fetch  = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.decode = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_mul)
                    state_next = ST_MUL;
                else if (sts.need_div)
                    state_next = ST_DIV;
                else if (sts.need_mem)
                    state_next = ST_MEM;
                else
                    state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul_fin = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_fin = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MEM:
            begin
                cmd.mem_fin = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

>>> hdl/mic_datapath.sv
// Datapath: byte-lane memory, register file, pc/hi/lo, ALU, multiplier, result registers.
// Depends on mic_pkg and instantiates mic_div.
`default_nettype none
module mic_datapath #(
    parameter int MEM_BYTES = 1048576
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mic_pkg::cmd_t cmd,
    output mic_pkg::sts_t sts,
    input  logic [19:0]   load_address,
    input  logic [31:0]   load_data,
    output logic          done,
    output logic [31:0]   program_counter,
    output logic [31:0]   fetched_word,
    output logic          executed,
    output logic          halted,
    output logic          reg_written,
    output logic [4:0]    reg_index,
    output logic [31:0]   reg_value,
    output logic          mem_fault
);
    import mic_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int RW   = $clog2(ROWS);
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

    function automatic logic addr_ok(input logic [31:0] a);
        return ({1'b0, a} + 33'd3) < MEM_LIMIT;
    endfunction

    // architectural state
    logic [31:0] pc_reg, hi_reg, lo_reg, ir_reg;
    logic [63:0] prod_reg;
    logic        negq_reg, negr_reg;
    logic [31:0] a_val, b_val;

    // ---------------- byte-lane memory ----------------
    logic [7:0]       mem [4][ROWS];
    logic [AW-1:0]    m_addr;
    logic             m_we;
    logic [31:0]      m_wdata;
    logic [RW-1:0]    row [4];
    logic [7:0]       wbyte [4];
    logic [7:0]       rbyte_reg [4];
    logic [1:0]       rlo_reg;
    logic [31:0]      mdata;
    logic [31:0]      la32, eff;
    logic             eff_ok;

    assign la32 = 32'(load_address);

    always_comb
    begin
        m_addr  = pc_reg[AW-1:0];
        m_wdata = load_data;
        if (cmd.load)
            m_addr = la32[AW-1:0];
        else if (cmd.decode)
            m_addr = AW'(pc_reg + INSTR_BYTES);
        else if (cmd.exec)
        begin
            m_addr  = eff[AW-1:0];
            m_wdata = b_val;
        end
    end

    always_comb
    begin
        logic [1:0] off;
        for (int k = 0; k < 4; k++)
        begin
            off      = 2'(k) - m_addr[1:0];
            row[k]   = RW'(({1'b0, m_addr} + (AW+1)'(off)) >> 2);
            wbyte[k] = m_wdata[31 - 8*off -: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (m_we)
                mem[k][row[k]] <= wbyte[k];
            rbyte_reg[k] <= mem[k][row[k]];
        end
        rlo_reg <= m_addr[1:0];
    end

    always_comb
    begin
        logic [1:0] idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = rlo_reg + 2'(i);
            mdata[31 - 8*i -: 8] = rbyte_reg[idx];
        end
    end

    // ---------------- register file ----------------
    logic [31:0] rf [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] a_raw_reg, b_raw_reg;
    logic        a_vld_reg, b_vld_reg;
    logic [4:0]  ra_reg, rb_reg, ra, rb;
    logic        rf_we;
    logic [4:0]  rf_wi;
    logic [31:0] rf_wv;

    assign ra = mdata[25:21];
    assign rb = mdata[20:16];

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_wi] <= rf_wv;
        a_raw_reg <= rf[ra];
        b_raw_reg <= rf[rb];
        ra_reg    <= ra;
        rb_reg    <= rb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_vld_reg[rf_wi] <= 1'b1;
            a_vld_reg <= rf_vld_reg[ra];
            b_vld_reg <= rf_vld_reg[rb];
        end
    end

    // an entry never written reads its reset value
    assign a_val = a_vld_reg ? a_raw_reg : ((ra_reg == 5'd31) ? EXIT_ADDRESS : 32'd0);
    assign b_val = b_vld_reg ? b_raw_reg : ((rb_reg == 5'd31) ? EXIT_ADDRESS : 32'd0);

    // ---------------- execute ----------------
    logic [5:0]  op, fn;
    logic [4:0]  rs_t, rd_d;
    logic [31:0] imm;
    logic        ex_wr, ex_fault, is_mul, is_div, is_lw, is_sw, sgn;
    logic [4:0]  ex_idx;
    logic [31:0] ex_val, pc_new, branch_pc;

    assign op        = ir_reg[31:26];
    assign fn        = ir_reg[5:0];
    assign rs_t      = ir_reg[20:16];
    assign rd_d      = ir_reg[15:11];
    assign imm       = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign eff       = a_val + imm;
    assign eff_ok    = addr_ok(eff);
    assign branch_pc = pc_reg + {imm[29:0], 2'b00};
    assign is_mul    = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
    assign is_div    = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU);
    assign sgn       = (fn == FN_MULT) || (fn == FN_DIV);
    assign is_lw     = (op == OP_LW);
    assign is_sw     = (op == OP_SW);

    always_comb
    begin
        ex_wr    = 1'b0;
        ex_idx   = rd_d;
        ex_val   = '0;
        ex_fault = 1'b0;
        pc_new   = pc_reg;
        case (op)
            OP_SPECIAL:
            begin
                case (fn)
                    FN_ADD:  begin ex_wr = 1'b1; ex_val = a_val + b_val; end
                    FN_SUB:  begin ex_wr = 1'b1; ex_val = a_val - b_val; end
                    FN_MFHI: begin ex_wr = 1'b1; ex_val = hi_reg; end
                    FN_MFLO: begin ex_wr = 1'b1; ex_val = lo_reg; end
                    FN_SLT:
                    begin
                        ex_wr  = 1'b1;
                        ex_val = 32'($signed(a_val) < $signed(b_val));
                    end
                    FN_SLTU:
                    begin
                        ex_wr  = 1'b1;
                        ex_val = 32'(a_val < b_val);
                    end
                    FN_LIS:
                    begin
                        ex_wr  = 1'b1;
                        ex_val = addr_ok(pc_reg) ? mdata : 32'd0;
                        pc_new = pc_reg + INSTR_BYTES;
                    end
                    FN_JR:   pc_new = a_val;
                    FN_JALR:
                    begin
                        ex_wr  = 1'b1;
                        ex_idx = 5'd31;
                        ex_val = pc_reg;
                        pc_new = a_val;
                    end
                    default: ex_wr = 1'b0;
                endcase
            end
            OP_BEQ: if (a_val == b_val) pc_new = branch_pc;
            OP_BNE: if (a_val != b_val) pc_new = branch_pc;
            OP_LW:
            begin
                ex_idx = rs_t;
                if (!eff_ok)
                begin
                    ex_wr    = 1'b1;
                    ex_fault = 1'b1;
                end
            end
            OP_SW:   ex_fault = !eff_ok;
            default: ex_wr = 1'b0;
        endcase
        if (ex_idx == 5'd0)
            ex_wr = 1'b0;
    end

    assign sts.pc_ok    = addr_ok(pc_reg);
    assign sts.need_mul = is_mul;
    assign sts.need_div = is_div && (b_val != 32'd0);
    assign sts.need_mem = is_lw && eff_ok;

    assign m_we = (cmd.load && addr_ok(la32)) || (cmd.exec && is_sw && eff_ok);

    always_comb
    begin
        rf_we = 1'b0;
        rf_wi = ex_idx;
        rf_wv = ex_val;
        if (cmd.exec && ex_wr)
            rf_we = 1'b1;
        else if (cmd.mem_fin && rs_t != 5'd0)
        begin
            rf_we = 1'b1;
            rf_wi = rs_t;
            rf_wv = mdata;
        end
    end

    // ---------------- multiply / divide ----------------
    logic [65:0] prod_full;
    logic [31:0] ua, ub, quo, rem;

    assign prod_full = 66'($signed({sgn & a_val[31], a_val}) * $signed({sgn & b_val[31], b_val}));
    assign ua = (sgn && a_val[31]) ? (32'd0 - a_val) : a_val;
    assign ub = (sgn && b_val[31]) ? (32'd0 - b_val) : b_val;

    mic_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.exec && sts.need_div),
        .dividend  (ua),
        .divisor   (ub),
        .done      (sts.div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            prod_reg <= prod_full[63:0];
            negq_reg <= sgn & (a_val[31] ^ b_val[31]);
            negr_reg <= sgn & a_val[31];
        end
    end

    // ---------------- pc, hi, lo ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            if (cmd.decode)
                pc_reg <= pc_reg + INSTR_BYTES;
            else if (cmd.exec)
                pc_reg <= pc_new;
            if (cmd.mul_fin)
            begin
                hi_reg <= prod_reg[63:32];
                lo_reg <= prod_reg[31:0];
            end
            else if (cmd.div_fin)
            begin
                lo_reg <= negq_reg ? (32'd0 - quo) : quo;
                hi_reg <= negr_reg ? (32'd0 - rem) : rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
            ir_reg <= mdata;
    end

    // ---------------- result registers ----------------
    logic        done_reg, exe_fin;
    logic [31:0] out_pc_reg, out_word_reg, out_val_reg;
    logic        out_exe_reg, out_halt_reg, out_wr_reg, out_fault_reg;
    logic [4:0]  out_idx_reg;

    assign exe_fin = cmd.exec && !sts.need_mul && !sts.need_div && !sts.need_mem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.load | cmd.halt | exe_fin | cmd.mul_fin | cmd.div_fin
                        | cmd.mem_fin;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.halt)
        begin
            out_pc_reg    <= pc_reg;
            out_word_reg  <= '0;
            out_exe_reg   <= 1'b0;
            out_halt_reg  <= cmd.halt;
            out_wr_reg    <= 1'b0;
            out_idx_reg   <= '0;
            out_val_reg   <= '0;
            out_fault_reg <= 1'b0;
        end
        else if (exe_fin || cmd.mul_fin || cmd.div_fin || cmd.mem_fin)
        begin
            out_pc_reg    <= exe_fin ? pc_new : pc_reg;
            out_word_reg  <= ir_reg;
            out_exe_reg   <= 1'b1;
            out_halt_reg  <= 1'b0;
            out_wr_reg    <= rf_we;
            out_idx_reg   <= rf_we ? rf_wi : 5'd0;
            out_val_reg   <= rf_we ? rf_wv : 32'd0;
            out_fault_reg <= exe_fin & ex_fault;
        end
    end

    assign done            = done_reg;
    assign program_counter = out_pc_reg;
    assign fetched_word    = out_word_reg;
    assign executed        = out_exe_reg;
    assign halted          = out_halt_reg;
    assign reg_written     = out_wr_reg;
    assign reg_index       = out_idx_reg;
    assign reg_value       = out_val_reg;
    assign mem_fault       = out_fault_reg;
endmodule
`default_nettype wire

>>> hdl/mips_integer_subset_cpu.sv
// Top level: load items store a program word, and halt items report the halt.
// A step runs fetch, decode and execute; mult/multu and lw add a product or memory
// stage, and div/divu wait for the radix-2 divider, one bit per cycle.
// One item at a time; busy stays high until the result strobe. done is a one-cycle
// strobe that the receiver cannot stall. rst_n clears pc, hi, lo, register file
// (r31 = 4092) and control; program memory holds no reset value.
`default_nettype none
module mips_integer_subset_cpu #(
    parameter int MEM_BYTES = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [19:0] load_address,
    input  logic [31:0] load_data,
    output logic        done,
    output logic [31:0] program_counter,
    output logic [31:0] fetched_word,
    output logic        executed,
    output logic        halted,
    output logic        reg_written,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        mem_fault
);
    import mic_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mic_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    mic_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .load_address    (load_address),
        .load_data       (load_data),
        .done            (done),
        .program_counter (program_counter),
        .fetched_word    (fetched_word),
        .executed        (executed),
        .halted          (halted),
        .reg_written     (reg_written),
        .reg_index       (reg_index),
        .reg_value       (reg_value),
        .mem_fault       (mem_fault)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while a transaction is in flight");

    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !opcode) |=> done)
        else $error("program word transaction did not complete in one cycle");

    a_halt_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && halted) |-> (!executed && !reg_written))
        else $error("halted result also reports execution");

    a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && reg_written) |-> (reg_index != 5'd0))
        else $error("write to register zero reported");
endmodule
`default_nettype wire
